FILE: hw/rtl/pce_pkg.sv
`timescale 1ns / 1ps

package pce_pkg;

  typedef enum logic [2:0] {
    RATE_1_3 = 3'd0,
    RATE_1_2 = 3'd1,
    RATE_4_7 = 3'd2,
    RATE_2_3 = 3'd3,
    RATE_4_5 = 3'd4
  } rate_t;

  localparam logic [2:0] RATE_RESET = RATE_1_2;

  localparam int unsigned PatternLen = 4;
  localparam int unsigned PairLen    = 2;

  typedef struct packed {
    logic info_bit;
    logic frame_end;
  } in_t;

  typedef struct packed {
    logic coded_bit;
    logic run_last;
    logic length_error;
  } out_t;

  // One encoded input bit waiting to be sent: mother bits X,Y,Z in bits 0,1,2.
  typedef struct packed {
    logic [2:0] bits;
    logic [1:0] cnt;
    logic       err;
  } job_t;

endpackage

FILE: hw/rtl/pce_encoder.sv
`timescale 1ns / 1ps

module pce_encoder (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_data,
  input  logic          acc,
  input  pce_pkg::in_t  in_item,
  output pce_pkg::job_t job
);
  import pce_pkg::*;

  logic [2:0] code_rate_r;
  logic [5:0] delay_r, delay_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       b;
  logic       x_bit, y_bit, z_bit;

  assign b = in_item.info_bit;
  assign x_bit = b ^ delay_r[1] ^ delay_r[2] ^ delay_r[4] ^ delay_r[5];
  assign y_bit = b ^ delay_r[0] ^ delay_r[1] ^ delay_r[2] ^ delay_r[3] ^ delay_r[5];
  assign z_bit = b ^ delay_r[0] ^ delay_r[1] ^ delay_r[3] ^ delay_r[5];

  always_comb begin
    job.bits = {z_bit, y_bit, x_bit};
    job.cnt  = 2'd2;
    job.err  = 1'b0;
    unique case (code_rate_r)
      RATE_1_3: begin
        job.cnt = 2'd3;
      end
      RATE_4_7: begin
        job.cnt = (phase_r == 2'd1) ? 2'd1 : 2'd2;
        job.err = in_item.frame_end && (phase_r != 2'(PatternLen - 1));
      end
      RATE_2_3: begin
        job.cnt = phase_r[0] ? 2'd1 : 2'd2;
        job.err = in_item.frame_end && (phase_r[0] != 1'(PairLen - 1));
      end
      RATE_4_5: begin
        job.cnt = (phase_r == 2'd0) ? 2'd2 : 2'd1;
        job.err = in_item.frame_end && (phase_r != 2'(PatternLen - 1));
      end
      default: begin
        job.cnt = 2'd2;
      end
    endcase
  end

  always_comb begin
    delay_nxt = delay_r;
    phase_nxt = phase_r;
    if (acc) begin
      if (in_item.frame_end) begin
        delay_nxt = '0;
        phase_nxt = '0;
      end else begin
        delay_nxt = {delay_r[4:0], b};
        phase_nxt = phase_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_rate_r <= RATE_RESET;
      delay_r     <= '0;
      phase_r     <= '0;
    end else begin
      if (cfg_we) begin
        code_rate_r <= cfg_data;
      end
      delay_r <= delay_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

FILE: hw/rtl/pce_serializer.sv
`timescale 1ns / 1ps

module pce_serializer (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  pce_pkg::job_t  job_in,
  output logic           full,
  output logic           out_valid,
  input  logic           out_stall,
  output pce_pkg::out_t  out_data
);
  import pce_pkg::*;

  job_t       pend_r, cur_r;
  logic       pend_vld_r, cur_vld_r;
  logic [1:0] idx_r, idx_nxt;
  logic       last_bit;
  logic       done;
  logic       move;

  // pending slot frees up in the same cycle it moves up, so a new request can land there
  assign full      = pend_vld_r && !move;
  assign last_bit  = (idx_r == cur_r.cnt - 2'd1);
  assign done      = cur_vld_r && !out_stall && last_bit;
  // pending request moves up when the current one is absent or finishing
  assign move      = pend_vld_r && (!cur_vld_r || done);

  assign out_valid             = cur_vld_r;
  assign out_data.coded_bit    = cur_r.bits[idx_r];
  assign out_data.run_last     = last_bit;
  assign out_data.length_error = cur_r.err;

  always_comb begin
    idx_nxt = idx_r;
    if (move || done) begin
      idx_nxt = '0;
    end else if (cur_vld_r && !out_stall) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      cur_vld_r  <= 1'b0;
      idx_r      <= '0;
    end else begin
      idx_r <= idx_nxt;
      if (load) begin
        pend_vld_r <= 1'b1;
      end else if (move) begin
        pend_vld_r <= 1'b0;
      end
      if (move) begin
        cur_vld_r <= 1'b1;
      end else if (done) begin
        cur_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pend_r <= job_in;
    end
    if (move) begin
      cur_r <= pend_r;
    end
  end

endmodule

FILE: hw/rtl/punctured_conv_encoder_k7.sv
`timescale 1ns / 1ps

// Punctured K=7 convolutional encoder, mother code 133/175/165 octal.
// Input channel (in_valid/in_stall/in_data): one information bit per request,
// with frame_end marking the last bit of a frame; the delay line and the
// puncture phase clear after that bit.
// Output channel (out_valid/out_stall/out_data): one coded bit per request,
// 1 to 3 per input bit in X, Y, Z order; run_last marks the last one and
// length_error flags a frame that stopped mid-pattern.
// cfg_we/cfg_data write code_rate (0:1/3 1:1/2 2:4/7 3:2/3 4:4/5, others 1/2);
// write it only while idle. Reset selects rate 1/2 and empties the pipe.
// With the output idle, an input passes through the pending register and then
// the current register before its first coded bit is presented.
// Each input bit sends its coded bits (1 to 3) one after another through
// the single output port; one pending input register lets the next bit
// enter while the current one is still sending.
// When the receiver stalls, the output holds, the pending register fills and
// in_stall rises until it drains.

module punctured_conv_encoder_k7 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_data,
  input  logic          in_valid,
  output logic          in_stall,
  input  pce_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pce_pkg::out_t out_data
);
  import pce_pkg::*;

  job_t job;
  logic acc;
  logic full;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  pce_encoder u_enc (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .acc      (acc),
    .in_item  (in_data),
    .job      (job)
  );

  pce_serializer u_ser (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (acc),
    .job_in    (job),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: test/tb_punctured_conv_encoder_k7.sv
`timescale 1ns / 1ps

module tb_punctured_conv_encoder_k7;
  import pce_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [2:0] RATE_SPARE_FIRST = 3'd5;
  localparam logic [2:0] RATE_SPARE_LAST = 3'd7;
  localparam logic [1:0] PHASE_LAST = 2'(PatternLen - 1);

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Encoder shadow state
  logic [2:0] rate_q = RATE_RESET;
  logic [5:0] delay_q = '0;
  logic [1:0] phase_q = '0;

  out_t pending_coded_bits[$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned bits_sent = 0;
  int unsigned coded_checked = 0;
  int unsigned rate_writes = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;

  punctured_conv_encoder_k7 u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d coded bits outstanding", cycle_count,
               pending_coded_bits.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= (snk_idle_pct != 0) && ($urandom_range(99) < snk_idle_pct);
  end

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  // Mother code X/Y/Z, then puncture by rate and phase
  function automatic void encode_bit(input logic b, input logic fe);
    logic [2:0] mother;
    int unsigned n;
    logic err;
    out_t r;
    mother[0] = b ^ delay_q[1] ^ delay_q[2] ^ delay_q[4] ^ delay_q[5];
    mother[1] = b ^ delay_q[0] ^ delay_q[1] ^ delay_q[2] ^ delay_q[3] ^ delay_q[5];
    mother[2] = b ^ delay_q[0] ^ delay_q[1] ^ delay_q[3] ^ delay_q[5];
    n = 2;
    err = 1'b0;
    case (rate_q)
      RATE_1_3: n = 3;
      RATE_4_7: begin
        n = (phase_q == 2'd1) ? 1 : 2;
        err = fe && (phase_q != PHASE_LAST);
      end
      RATE_2_3: begin
        n = phase_q[0] ? 1 : 2;
        err = fe && !phase_q[0];
      end
      RATE_4_5: begin
        n = (phase_q == 2'd0) ? 2 : 1;
        err = fe && (phase_q != PHASE_LAST);
      end
      default: n = 2;
    endcase
    for (int k = 0; k < n; k++) begin
      r.coded_bit = mother[k];
      r.run_last = (k == n - 1);
      r.length_error = err;
      pending_coded_bits = {pending_coded_bits, r};
    end
    if (fe) begin
      delay_q = '0;
      phase_q = '0;
    end else begin
      delay_q = {delay_q[4:0], b};
      phase_q = phase_q + 2'd1;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_coded_bits.size() == 0) begin
        note_mismatch($sformatf("unexpected coded bit %b", out_data));
      end else begin
        out_t want;
        want = pending_coded_bits.pop_front();
        coded_checked++;
        if (out_data.coded_bit !== want.coded_bit)
          note_mismatch($sformatf("coded_bit got %b want %b", out_data.coded_bit,
                                  want.coded_bit));
        if (out_data.run_last !== want.run_last)
          note_mismatch($sformatf("run_last got %b want %b", out_data.run_last,
                                  want.run_last));
        if (out_data.length_error !== want.length_error)
          note_mismatch($sformatf("length_error got %b want %b", out_data.length_error,
                                  want.length_error));
      end
    end
  end

  task automatic send_bit(input logic b, input logic fe);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{info_bit: b, frame_end: fe};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    encode_bit(b, fe);
    bits_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_coded_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [2:0] r);
    drain_results();
    cfg_data <= r;
    cfg_we <= 1'b1;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_q = r;
    rate_writes++;
  endtask

  function automatic logic [2:0] pick_rate();
    if ($urandom_range(3) == 0) return 3'($urandom_range(7));
    return 3'($urandom_range(RATE_4_5));
  endfunction

  // Reset rate 1/2; seven ones fill the delay line before the frame ends
  task automatic test_reset_rate();
    repeat (7) send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);
  endtask

  // One short frame for each rate but 1/2, complete and incomplete endings
  task automatic test_each_rate();
    write_rate(RATE_1_3);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b1);
    write_rate(RATE_4_7);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b1);
    write_rate(RATE_2_3);
    send_bit(1'b1, 1'b1);
    write_rate(RATE_4_5);
    send_bit(1'b0, 1'b0);
    send_bit(1'b1, 1'b0);
    send_bit(1'b1, 1'b1);
  endtask

  // Phase keeps running across a rate change; spare codes act as 1/2
  task automatic test_rate_change_mid_frame();
    write_rate(RATE_4_5);
    send_bit(1'b1, 1'b0);
    send_bit(1'b0, 1'b0);
    write_rate(RATE_2_3);
    send_bit(1'b1, 1'b0);
    write_rate(RATE_SPARE_LAST);
    send_bit(1'b1, 1'b1);
    write_rate(RATE_SPARE_FIRST);
    send_bit(1'b0, 1'b1);
  endtask

  // Random frames; a few lose their frame end so state runs on
  task automatic test_random_frames(input int unsigned n_items);
    int unsigned sent;
    int unsigned frame_len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) write_rate(pick_rate());
      frame_len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
      for (int unsigned k = 1; k <= frame_len; k++) begin
        if (k == frame_len / 2 + 1 && $urandom_range(9) == 0) write_rate(pick_rate());
        send_bit(1'($urandom_range(1)), (k == frame_len) && ($urandom_range(15) != 0));
        sent++;
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_idle_pct = 20;
    snk_idle_pct = 74;
    test_reset_rate();
    test_each_rate();
    test_rate_change_mid_frame();
    test_random_frames(140);

    src_idle_pct = 74;
    snk_idle_pct = 20;
    test_random_frames(140);

    src_idle_pct = 0;
    snk_idle_pct = 0;
    test_random_frames(140);

    drain_results();
    repeat (10) @(posedge clk);

    $display("Sent %0d info bits over all code rates incl. spare codes and mid-frame changes;",
             bits_sent);
    $display("checked %0d coded bits after %0d rate writes, %0d mismatches.",
             coded_checked, rate_writes, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/pce_pkg.sv
hw/rtl/pce_encoder.sv
hw/rtl/pce_serializer.sv
hw/rtl/punctured_conv_encoder_k7.sv
test/tb_punctured_conv_encoder_k7.sv
